// ===== src/ddci_pkg.sv =====
// ----------------------------------------------------------------------------
// ddci_pkg
// Shared types and constants for the depth-dose curve interpolator: word
// layouts, opcodes, status codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ddci_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = 7;
  localparam int DEPTH_W    = 16;
  localparam int DOSE_W     = 16;
  localparam int ACC_W      = 35;
  localparam int MAG_W      = 34;
  localparam int DIV_STEPS  = MAG_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [DEPTH_W-1:0]        depth_in;
    logic signed [DOSE_W-1:0]  dose_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [DOSE_W-1:0]  dose_out;
    logic [DEPTH_W-1:0]        depth_out;
    logic [CNT_W-1:0]          points_held;
  } out_word_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]        depth;
    logic signed [DOSE_W-1:0]  dose;
  } point_t;

  localparam int POINT_W = $bits(point_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD0,
    S_CMP,
    S_MUL1,
    S_MUL2,
    S_SIGN,
    S_DIV,
    S_FIN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic scan_first;
    logic scan_cmp;
    logic mul_first;
    logic mul_second;
    logic div_init;
    logic div_step;
    logic div_finish;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       few_points;
    logic       hit;
    logic       den_zero;
    logic       scan_last;
    logic       div_last;
  } dp_stat_t;

endpackage

// ===== src/depth_dose_curve_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// depth_dose_curve_interpolator_core
// Piecewise linear depth-dose table with clear, append and interpolated query.
// ----------------------------------------------------------------------------
// One word is worked on at a time. Clear, append, the unused opcode and a
// query on fewer than two points go from accept through execute straight to
// the response. A query otherwise scans the point pairs in order (up to 63
// pairs with a full table), and one that finds no pair, or a pair of equal
// depths, goes from the scan straight to the response. The table sits in a
// RAM with one write and one read port, read one point per cycle, and the
// dose comes from a 34-step restoring divider after two passes through one
// shared multiplier. A finished result waits in the output register while
// the next word is accepted. No clearing pass is needed after reset.
module depth_dose_curve_interpolator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ddci_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ddci_pkg::out_word_t out_data
);

  ddci_pkg::dp_cmd_t  cmd;
  ddci_pkg::dp_stat_t stat;

  ddci_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ddci_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== src/ddci_ram.sv =====
// ----------------------------------------------------------------------------
// ddci_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ddci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/ddci_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddci_ctrl
// Controller: sequences one word at a time through execute, table scan,
// multiply, divide and response, and owns the output valid flag.
// ----------------------------------------------------------------------------
module ddci_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ddci_pkg::dp_stat_t stat,
  output ddci_pkg::dp_cmd_t  cmd
);

  ddci_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ddci_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ddci_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ddci_pkg::S_EXEC;
      end
      ddci_pkg::S_EXEC: begin
        if (stat.op == ddci_pkg::OP_QUERY && !stat.few_points) begin
          state_nxt = ddci_pkg::S_LOAD0;
        end else begin
          state_nxt = ddci_pkg::S_RESP;
        end
      end
      ddci_pkg::S_LOAD0: state_nxt = ddci_pkg::S_CMP;
      ddci_pkg::S_CMP: begin
        if (stat.hit) begin
          state_nxt = stat.den_zero ? ddci_pkg::S_RESP : ddci_pkg::S_MUL1;
        end else if (stat.scan_last) begin
          state_nxt = ddci_pkg::S_RESP;
        end
      end
      ddci_pkg::S_MUL1: state_nxt = ddci_pkg::S_MUL2;
      ddci_pkg::S_MUL2: state_nxt = ddci_pkg::S_SIGN;
      ddci_pkg::S_SIGN: state_nxt = ddci_pkg::S_DIV;
      ddci_pkg::S_DIV: begin
        if (stat.div_last) state_nxt = ddci_pkg::S_FIN;
      end
      ddci_pkg::S_FIN: state_nxt = ddci_pkg::S_RESP;
      ddci_pkg::S_RESP: begin
        if (out_free) state_nxt = ddci_pkg::S_IDLE;
      end
      default: state_nxt = ddci_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load_in    = (state_r == ddci_pkg::S_IDLE) && in_valid;
    cmd.exec       = (state_r == ddci_pkg::S_EXEC);
    cmd.scan_first = (state_r == ddci_pkg::S_LOAD0);
    cmd.scan_cmp   = (state_r == ddci_pkg::S_CMP);
    cmd.mul_first  = (state_r == ddci_pkg::S_MUL1);
    cmd.mul_second = (state_r == ddci_pkg::S_MUL2);
    cmd.div_init   = (state_r == ddci_pkg::S_SIGN);
    cmd.div_step   = (state_r == ddci_pkg::S_DIV);
    cmd.div_finish = (state_r == ddci_pkg::S_FIN);
    cmd.load_out   = (state_r == ddci_pkg::S_RESP) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddci_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/ddci_dp.sv =====
// ----------------------------------------------------------------------------
// ddci_dp
// Datapath: point table, append checks, pairwise table scan, shared
// multiplier, restoring divider and the output word register.
// ----------------------------------------------------------------------------
module ddci_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ddci_pkg::in_word_t  in_data,
  output ddci_pkg::out_word_t out_data,
  input  ddci_pkg::dp_cmd_t   cmd,
  output ddci_pkg::dp_stat_t  stat
);

  // input word
  logic [1:0]                          op_r;
  logic [ddci_pkg::DEPTH_W-1:0]        x_r;
  logic signed [ddci_pkg::DOSE_W-1:0]  din_r;

  // table state
  logic [ddci_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [ddci_pkg::DEPTH_W-1:0]        last_depth_r;
  logic [ddci_pkg::CNT_W-1:0]          idx_r;

  // scan
  ddci_pkg::point_t                    prev_r;
  ddci_pkg::point_t                    cur;
  logic [ddci_pkg::POINT_W-1:0]        rd_data;
  logic                                wr_en;
  ddci_pkg::point_t                    wr_point;

  // arithmetic
  logic signed [ddci_pkg::DOSE_W-1:0]  dose1_r;
  logic signed [ddci_pkg::DOSE_W:0]    diff_r;
  logic [ddci_pkg::DEPTH_W-1:0]        den_r;
  logic [ddci_pkg::DEPTH_W-1:0]        num_r;
  logic signed [ddci_pkg::DOSE_W:0]    mul_a;
  logic [ddci_pkg::DEPTH_W-1:0]        mul_b;
  logic signed [2*ddci_pkg::DOSE_W+1:0] prod;
  logic signed [ddci_pkg::ACC_W-1:0]   prod_ext;
  logic signed [ddci_pkg::ACC_W-1:0]   acc_r;
  logic [ddci_pkg::ACC_W-1:0]          acc_neg;
  logic                                neg_r;
  logic [ddci_pkg::MAG_W-1:0]          quo_r;
  logic [ddci_pkg::DEPTH_W-1:0]        rem_r;
  logic [ddci_pkg::DEPTH_W:0]          trial;
  logic                                trial_ge;
  logic [ddci_pkg::DEPTH_W:0]          trial_sub;
  logic [ddci_pkg::DIV_CNT_W-1:0]      dcnt_r;
  logic [ddci_pkg::DOSE_W-1:0]         quo_neg;

  // result
  logic [1:0]                          status_r;
  logic signed [ddci_pkg::DOSE_W-1:0]  dose_res_r;
  ddci_pkg::out_word_t                 out_r;

  logic                                app_full;
  logic                                app_order;

  assign cur = ddci_pkg::point_t'(rd_data);

  assign app_full  = (count_r >= ddci_pkg::CNT_W'(ddci_pkg::MAX_POINTS));
  assign app_order = (count_r != '0) && (x_r <= last_depth_r);
  assign wr_en     = cmd.exec && (op_r == ddci_pkg::OP_APPEND) && !app_full && !app_order;
  assign wr_point  = '{depth: x_r, dose: din_r};

  ddci_ram #(
    .WIDTH (ddci_pkg::POINT_W),
    .DEPTH (ddci_pkg::MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ddci_pkg::ADDR_W-1:0]),
    .wr_data (wr_point),
    .rd_addr (idx_r[ddci_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // shared multiplier: dose1 * den, then diff * num
  assign mul_a    = cmd.mul_second ? diff_r : {dose1_r[ddci_pkg::DOSE_W-1], dose1_r};
  assign mul_b    = cmd.mul_second ? num_r : den_r;
  assign prod     = mul_a * $signed({1'b0, mul_b});
  assign prod_ext = {prod[$high(prod)], prod};
  assign acc_neg  = '0 - acc_r;

  // restoring divide, one quotient bit per cycle
  assign trial     = {rem_r, quo_r[ddci_pkg::MAG_W-1]};
  assign trial_ge  = (trial >= {1'b0, den_r});
  assign trial_sub = trial - {1'b0, den_r};
  assign quo_neg   = '0 - quo_r[ddci_pkg::DOSE_W-1:0];

  always_comb begin
    count_nxt = count_r;
    if (cmd.exec && op_r == ddci_pkg::OP_CLEAR) begin
      count_nxt = '0;
    end else if (wr_en) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_data.opcode;
      x_r   <= in_data.depth_in;
      din_r <= in_data.dose_in;
      idx_r <= '0;
    end

    if (cmd.exec) begin
      dose_res_r <= '0;
      idx_r      <= ddci_pkg::CNT_W'(1);
      case (op_r)
        ddci_pkg::OP_APPEND: begin
          if (app_full) begin
            status_r <= ddci_pkg::ST_FULL;
          end else if (app_order) begin
            status_r <= ddci_pkg::ST_ORDER;
          end else begin
            status_r     <= ddci_pkg::ST_OK;
            last_depth_r <= x_r;
          end
        end
        ddci_pkg::OP_QUERY: begin
          status_r <= (count_r < ddci_pkg::CNT_W'(2)) ? ddci_pkg::ST_RANGE
                                                      : ddci_pkg::ST_OK;
        end
        default: status_r <= ddci_pkg::ST_OK;
      endcase
    end

    if (cmd.scan_first) begin
      prev_r <= cur;
      idx_r  <= ddci_pkg::CNT_W'(2);
    end

    if (cmd.scan_cmp) begin
      if (stat.hit) begin
        dose1_r <= prev_r.dose;
        diff_r  <= {cur.dose[ddci_pkg::DOSE_W-1], cur.dose}
                 - {prev_r.dose[ddci_pkg::DOSE_W-1], prev_r.dose};
        den_r   <= cur.depth - prev_r.depth;
        num_r   <= x_r - prev_r.depth;
        if (stat.den_zero) dose_res_r <= prev_r.dose;
      end else if (stat.scan_last) begin
        status_r <= ddci_pkg::ST_RANGE;
      end else begin
        prev_r <= cur;
        idx_r  <= idx_r + 1'b1;
      end
    end

    if (cmd.mul_first) begin
      acc_r <= prod_ext;
    end
    if (cmd.mul_second) begin
      acc_r <= acc_r + prod_ext;
    end

    if (cmd.div_init) begin
      neg_r  <= acc_r[ddci_pkg::ACC_W-1];
      quo_r  <= acc_r[ddci_pkg::ACC_W-1] ? acc_neg[ddci_pkg::MAG_W-1:0]
                                         : acc_r[ddci_pkg::MAG_W-1:0];
      rem_r  <= '0;
      dcnt_r <= '0;
    end

    if (cmd.div_step) begin
      rem_r  <= trial_ge ? trial_sub[ddci_pkg::DEPTH_W-1:0] : trial[ddci_pkg::DEPTH_W-1:0];
      quo_r  <= {quo_r[ddci_pkg::MAG_W-2:0], trial_ge};
      dcnt_r <= dcnt_r + 1'b1;
    end

    if (cmd.div_finish) begin
      dose_res_r <= neg_r ? quo_neg : quo_r[ddci_pkg::DOSE_W-1:0];
    end

    if (cmd.load_out) begin
      out_r <= '{status: status_r, dose_out: dose_res_r, depth_out: x_r,
                 points_held: count_r};
    end
  end

  always_comb begin
    stat            = '0;
    stat.op         = op_r;
    stat.few_points = (count_r < ddci_pkg::CNT_W'(2));
    stat.hit        = (x_r >= prev_r.depth) && (x_r <= cur.depth);
    stat.den_zero   = (cur.depth == prev_r.depth);
    stat.scan_last  = (idx_r == count_r);
    stat.div_last   = (dcnt_r == ddci_pkg::DIV_CNT_W'(ddci_pkg::DIV_STEPS - 1));
  end

  assign out_data = out_r;

endmodule

// ===== src/ddci_chk.sv =====
// ----------------------------------------------------------------------------
// ddci_chk
// Port-level checker for the depth-dose curve interpolator, bound to the top.
// ----------------------------------------------------------------------------
module ddci_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ddci_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input ddci_pkg::out_word_t out_data
);

  logic [2:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("output word without accepted input");

  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd2)
    else $error("too many words in flight");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ddci_pkg::ST_OK |-> out_data.dose_out == '0)
    else $error("failed word carries nonzero dose");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.points_held <= ddci_pkg::CNT_W'(ddci_pkg::MAX_POINTS))
    else $error("point count above table size");

endmodule

bind depth_dose_curve_interpolator_core ddci_chk u_chk (.*);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for depth_dose_curve_interpolator_core. A short table of
// directed words covers the empty, one-point and full-range cases, then
// random curves are built, broken and queried. Every accepted word is run
// through an in-bench curve table that predicts status, dose, depth echo and
// point count, and the results are compared in order.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WORD_GOAL  = 1250;
  localparam int HOLD_AT    = 3000;
  localparam int HOLD_LEN   = 400;
  localparam int CALM_FROM  = 8000;
  localparam int CALM_TO    = 11000;
  localparam int STUCK_MAX  = 4000;
  localparam int DRAIN_WAIT = 150;

  typedef struct packed {
    logic [1:0]          op;
    logic [15:0]         depth;
    logic [15:0]         dose;
    logic                check;
    ddci_pkg::out_word_t want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  ddci_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  ddci_pkg::out_word_t out_data;

  logic [15:0]        curve_depth [ddci_pkg::MAX_POINTS];
  logic signed [15:0] curve_dose [ddci_pkg::MAX_POINTS];
  int                 curve_len = 0;

  ddci_pkg::out_word_t pending_words [$];
  int        fails = 0;
  int        words_sent = 0;
  int        cycle = 0;
  int        stuck = 0;
  logic      calm;

  row_t directed [20] = '{
    {ddci_pkg::OP_QUERY, 16'h1234, 16'h0000, 1'b1, ddci_pkg::ST_RANGE, 16'h0000, 16'h1234, 7'd0},
    {ddci_pkg::OP_APPEND, 16'h0000, 16'h8000, 1'b1, ddci_pkg::ST_OK, 16'h0000, 16'h0000, 7'd1},
    {ddci_pkg::OP_QUERY, 16'h0000, 16'h0000, 1'b1, ddci_pkg::ST_RANGE, 16'h0000, 16'h0000, 7'd1},
    {ddci_pkg::OP_APPEND, 16'h0000, 16'h1111, 1'b1, ddci_pkg::ST_ORDER, 16'h0000, 16'h0000, 7'd1},
    {ddci_pkg::OP_APPEND, 16'hffff, 16'h7fff, 1'b1, ddci_pkg::ST_OK, 16'h0000, 16'hffff, 7'd2},
    {ddci_pkg::OP_QUERY, 16'h0000, 16'hffff, 1'b1, ddci_pkg::ST_OK, 16'h8000, 16'h0000, 7'd2},
    {ddci_pkg::OP_QUERY, 16'hffff, 16'h0000, 1'b1, ddci_pkg::ST_OK, 16'h7fff, 16'hffff, 7'd2},
    {ddci_pkg::OP_QUERY, 16'h8000, 16'h0000, 1'b0, 41'd0},
    {ddci_pkg::OP_QUERY, 16'h0001, 16'h0000, 1'b0, 41'd0},
    {OP_UNUSED, 16'h5555, 16'haaaa, 1'b1, ddci_pkg::ST_OK, 16'h0000, 16'h5555, 7'd2},
    {ddci_pkg::OP_APPEND, 16'h8000, 16'h0000, 1'b1, ddci_pkg::ST_ORDER, 16'h0000, 16'h8000, 7'd2},
    {ddci_pkg::OP_CLEAR, 16'h0042, 16'h1234, 1'b1, ddci_pkg::ST_OK, 16'h0000, 16'h0042, 7'd0},
    {ddci_pkg::OP_APPEND, 16'h0100, 16'h7fff, 1'b1, ddci_pkg::ST_OK, 16'h0000, 16'h0100, 7'd1},
    {ddci_pkg::OP_APPEND, 16'h0101, 16'h8000, 1'b1, ddci_pkg::ST_OK, 16'h0000, 16'h0101, 7'd2},
    {ddci_pkg::OP_APPEND, 16'h0300, 16'h0064, 1'b1, ddci_pkg::ST_OK, 16'h0000, 16'h0300, 7'd3},
    {ddci_pkg::OP_QUERY, 16'h00ff, 16'h0000, 1'b1, ddci_pkg::ST_RANGE, 16'h0000, 16'h00ff, 7'd3},
    {ddci_pkg::OP_QUERY, 16'h0301, 16'h0000, 1'b1, ddci_pkg::ST_RANGE, 16'h0000, 16'h0301, 7'd3},
    {ddci_pkg::OP_QUERY, 16'h0101, 16'h0000, 1'b0, 41'd0},
    {ddci_pkg::OP_QUERY, 16'h0200, 16'h0000, 1'b0, 41'd0},
    {ddci_pkg::OP_QUERY, 16'h0100, 16'h0000, 1'b1, ddci_pkg::ST_OK, 16'h7fff, 16'h0100, 7'd3}
  };

  depth_dose_curve_interpolator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign calm = (cycle >= CALM_FROM) && (cycle < CALM_TO);

  function automatic ddci_pkg::out_word_t curve_step(ddci_pkg::in_word_t w);
    ddci_pkg::out_word_t r;
    longint    span;
    longint    off;
    longint    rise;
    r.status      = ddci_pkg::ST_OK;
    r.dose_out    = '0;
    r.depth_out   = w.depth_in;
    case (w.opcode)
      ddci_pkg::OP_CLEAR: curve_len = 0;
      ddci_pkg::OP_APPEND: begin
        if (curve_len >= ddci_pkg::MAX_POINTS) begin
          r.status = ddci_pkg::ST_FULL;
        end else if (curve_len > 0 && w.depth_in <= curve_depth[curve_len-1]) begin
          r.status = ddci_pkg::ST_ORDER;
        end else begin
          curve_depth[curve_len] = w.depth_in;
          curve_dose[curve_len]  = w.dose_in;
          curve_len++;
        end
      end
      ddci_pkg::OP_QUERY: begin
        r.status = ddci_pkg::ST_RANGE;
        for (int i = 0; i + 1 < curve_len; i++) begin
          if (r.status == ddci_pkg::ST_RANGE && w.depth_in >= curve_depth[i] &&
              w.depth_in <= curve_depth[i+1]) begin
            r.status = ddci_pkg::ST_OK;
            span = longint'(curve_depth[i+1]) - longint'(curve_depth[i]);
            off  = longint'(w.depth_in) - longint'(curve_depth[i]);
            rise = longint'(curve_dose[i+1]) - longint'(curve_dose[i]);
            if (span == 0)
              r.dose_out = curve_dose[i];
            else
              r.dose_out = 16'((longint'(curve_dose[i]) * span + rise * off) / span);
          end
        end
      end
      default: ;
    endcase
    r.points_held = 7'(curve_len);
    return r;
  endfunction

  function automatic row_t word_row(logic [1:0] op, logic [15:0] depth, logic [15:0] dose);
    row_t r;
    r       = '0;
    r.op    = op;
    r.depth = depth;
    r.dose  = dose;
    return r;
  endfunction

  task automatic send_word(input row_t r);
    ddci_pkg::in_word_t  w;
    ddci_pkg::out_word_t guess;
    w.opcode   = r.op;
    w.depth_in = r.depth;
    w.dose_in  = r.dose;
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = curve_step(w);
    pending_words.insert(pending_words.size(), r.check ? r.want : guess);
    if (r.op != OP_UNUSED) words_sent++;
  endtask

  // receiver: random stalls, one long hold-off, a calm stretch
  initial begin
    int rx_cycles;
    int hold_left;
    rx_cycles = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 27);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word %h", out_data);
        fails++;
      end else begin
        ddci_pkg::out_word_t exp_w;
        exp_w = pending_words.pop_front();
        if (out_data.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, out_data.status);
          fails++;
        end
        if (out_data.dose_out !== exp_w.dose_out) begin
          $error("dose_out: expected %0d, got %0d", exp_w.dose_out, out_data.dose_out);
          fails++;
        end
        if (out_data.depth_out !== exp_w.depth_out) begin
          $error("depth_out: expected %0d, got %0d", exp_w.depth_out, out_data.depth_out);
          fails++;
        end
        if (out_data.points_held !== exp_w.points_held) begin
          $error("points_held: expected %0d, got %0d", exp_w.points_held,
                 out_data.points_held);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck == STUCK_MAX) begin
      $display("[depth_dose_curve_interpolator_core] ERROR");
      $finish;
    end
  end

  initial begin
    int pts;
    int stride;
    int next_d;
    int pick;
    int last_d;
    int nq;
    logic [15:0] qd;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_word(directed[i]);

    while (words_sent < WORD_GOAL) begin
      if ($urandom_range(99) < 85)
        send_word(word_row(ddci_pkg::OP_CLEAR, 16'($urandom()), 16'($urandom())));
      pts    = ($urandom_range(99) < 10) ? $urandom_range(64, 68) : $urandom_range(0, 12);
      stride = 65535 / (pts + 1);
      next_d = $urandom_range(0, stride);
      for (int j = 0; j < pts; j++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          last_d = (curve_len > 0) ? int'(curve_depth[curve_len-1]) : 65535;
          send_word(word_row(ddci_pkg::OP_APPEND, 16'($urandom_range(0, last_d)),
                             16'($urandom())));
        end else if (pick < 11) begin
          send_word(word_row(OP_UNUSED, 16'($urandom()), 16'($urandom())));
        end else begin
          send_word(word_row(ddci_pkg::OP_APPEND, 16'(next_d), 16'($urandom())));
          next_d += $urandom_range(1, stride);
        end
      end
      nq = $urandom_range(1, 8);
      for (int j = 0; j < nq; j++) begin
        pick = $urandom_range(99);
        if (curve_len > 0 && pick < 65)
          qd = 16'($urandom_range(int'(curve_depth[0]), int'(curve_depth[curve_len-1])));
        else if (curve_len > 0 && pick < 80)
          qd = curve_depth[$urandom_range(0, curve_len - 1)];
        else
          qd = 16'($urandom());
        send_word(word_row(ddci_pkg::OP_QUERY, qd, 16'($urandom())));
      end
    end
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0)
      $display("[depth_dose_curve_interpolator_core] OK");
    else
      $display("[depth_dose_curve_interpolator_core] ERROR");
    $finish;
  end

endmodule
